// ===== design/dssm_pkg.sv =====
// Shared types and codes for the drum step sequencer mixer.
package dssm_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] kind_t;
  typedef logic [2:0] hits_t;
  typedef logic [2:0] cfg_index_t;

  localparam cmd_t CMD_TICK       = 2'd0;
  localparam cmd_t CMD_LOAD_KICK  = 2'd1;
  localparam cmd_t CMD_LOAD_SNARE = 2'd2;
  localparam cmd_t CMD_STOP       = 2'd3;

  localparam kind_t KIND_IDLE  = 2'd0;
  localparam kind_t KIND_KICK  = 2'd1;
  localparam kind_t KIND_SNARE = 2'd2;
  localparam kind_t KIND_HIHAT = 2'd3;

  localparam hits_t HIT_KICK  = 3'h1;
  localparam hits_t HIT_SNARE = 3'h2;
  localparam hits_t HIT_HIHAT = 3'h4;

  localparam cfg_index_t REG_SAMPLES_PER_STEP = 3'd0;
  localparam cfg_index_t REG_STEP_COUNT       = 3'd1;
  localparam cfg_index_t REG_PATTERN          = 3'd2;
  localparam cfg_index_t REG_KICK_LENGTH      = 3'd3;
  localparam cfg_index_t REG_SNARE_LENGTH     = 3'd4;
  localparam cfg_index_t REG_PAUSED           = 3'd5;

  localparam int CFG_WIDTH  = 48;
  localparam int LEN_WIDTH  = 13;
  localparam int STEP_WIDTH = 4;
  localparam int SPS_WIDTH  = 20;

endpackage

// ===== design/dssm_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module dssm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/drum_step_sequencer_mixer_core.sv =====
// Drum step sequencer and voice mixer, top level.
//
//   channel   direction  beat moves                               handshake
//   in        input      command, sample_address, sample_value    in_valid / in_stall
//   out       output     audio_out                                out_valid / out_stall
//   cfg       input      cfg_index, cfg_data                      cfg_write
//
// A tick passes the fire state, which handles each hit in the step that fires (0 to 3
// hits), then the voice walk and the output state, before the next beat is taken. In the voice
// walk one voice per cycle reads its pair through the two read ports of its memory. A load
// passes the wrap state, which reduces its address once per wrap, then the output state; stop
// and a paused tick go straight to the output state. Synchronous reset idles voices and
// sequencer and restores register defaults; the sample memories keep their contents.
// A stalled result waits in the output register while the next beat is accepted and worked on.
module drum_step_sequencer_mixer_core #(
  parameter int VOICES       = 4,
  parameter int SAMPLE_DEPTH = 4096,
  parameter int MAX_STEPS    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dssm_pkg::cmd_t                 command,
  input  logic [11:0]                    sample_address,
  input  logic signed [15:0]             sample_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             audio_out,
  input  logic                           cfg_write,
  input  dssm_pkg::cfg_index_t           cfg_index,
  input  logic [dssm_pkg::CFG_WIDTH-1:0] cfg_data
);
  import dssm_pkg::*;

  localparam int AW  = $clog2(SAMPLE_DEPTH);
  localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW  = $clog2(VOICES + 1);
  localparam int SW  = 17 + $clog2(VOICES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRAP   = 3'd1;
  localparam logic [2:0] S_FIRE   = 3'd2;
  localparam logic [2:0] S_MIX    = 3'd3;
  localparam logic [2:0] S_OUTPUT = 3'd4;

  logic [2:0] state;

  // Configuration registers.
  logic [SPS_WIDTH-1:0] samples_per_step;
  logic [4:0]           step_count;
  logic [47:0]          pattern;
  logic [LEN_WIDTH-1:0] kick_length;
  logic [LEN_WIDTH-1:0] snare_length;
  logic                 paused;

  // Sequencer and voice state.
  logic [STEP_WIDTH-1:0] step_index;
  logic [SPS_WIDTH-1:0]  step_countdown;
  logic [LEN_WIDTH-1:0]  voice_position [VOICES];
  kind_t                 voice_kind [VOICES];

  logic [11:0]          ld_addr;
  logic [15:0]          ld_value;
  logic                 ld_kick;
  hits_t                hits;
  logic [CW-1:0]        mix_count;
  logic                 rd_active;
  logic                 rd_kick;
  logic signed [SW-1:0] acc;

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Step bookkeeping for a tick that fires.
  logic [4:0]            step_limit;
  logic [4:0]            step_inc;
  logic [SPS_WIDTH-1:0]  reload;
  always_comb begin
    if (step_count == 5'd0) begin
      step_limit = 5'd1;
    end else if (step_count > 5'(MAX_STEPS)) begin
      step_limit = 5'(MAX_STEPS);
    end else begin
      step_limit = step_count;
    end
    step_inc = {1'b0, step_index} + 5'd1;
    reload   = (samples_per_step == '0) ? SPS_WIDTH'(1) : samples_per_step;
  end

  // Claim: lowest pending hit takes the first idle voice.
  kind_t          claim_kind;
  logic           claim_found;
  logic [VIW-1:0] claim_idx;
  always_comb begin
    priority if (hits[0]) begin
      claim_kind = KIND_KICK;
    end else if (hits[1]) begin
      claim_kind = KIND_SNARE;
    end else begin
      claim_kind = KIND_HIHAT;
    end
    claim_found = 1'b0;
    claim_idx   = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (voice_kind[v] == KIND_IDLE) begin
        claim_found = 1'b1;
        claim_idx   = VIW'(v);
      end
    end
  end

  // Voice issue: addresses of the pair and the position after it.
  logic [VIW-1:0]       mv;
  logic                 mix_issue;
  logic                 mv_kick;
  logic [LEN_WIDTH-1:0] mv_pos;
  logic [LEN_WIDTH:0]   mv_pos_next;
  logic [LEN_WIDTH-1:0] eff_len;
  logic [31:0]          addr_b_wide;
  logic [AW-1:0]        raddr_a;
  logic [AW-1:0]        raddr_b;
  always_comb begin
    mv          = mix_count[VIW-1:0];
    mix_issue   = (state == S_MIX) && (mix_count < CW'(VOICES)) &&
                  (voice_kind[mv] != KIND_IDLE);
    mv_kick     = (voice_kind[mv] == KIND_KICK);
    mv_pos      = voice_position[mv];
    mv_pos_next = {1'b0, mv_pos} + (LEN_WIDTH+1)'(2);
    if (mv_kick) begin
      eff_len = (32'(kick_length) > SAMPLE_DEPTH) ? LEN_WIDTH'(SAMPLE_DEPTH) : kick_length;
    end else begin
      eff_len = (32'(snare_length) > SAMPLE_DEPTH) ? LEN_WIDTH'(SAMPLE_DEPTH) : snare_length;
    end
    // An active position always lies below the depth, so only the second word can wrap.
    addr_b_wide = 32'(mv_pos) + 32'd1;
    if (addr_b_wide == SAMPLE_DEPTH) begin
      addr_b_wide = 32'd0;
    end
    raddr_a = AW'(32'(mv_pos));
    raddr_b = AW'(addr_b_wide);
  end

  // Load address reduction and memory writes.
  logic          wrap_more;
  logic          we_kick;
  logic          we_snare;
  logic [AW-1:0] waddr;
  assign wrap_more = (32'(ld_addr) >= SAMPLE_DEPTH);
  assign we_kick   = (state == S_WRAP) && !wrap_more && ld_kick;
  assign we_snare  = (state == S_WRAP) && !wrap_more && !ld_kick;
  assign waddr     = AW'(32'(ld_addr));

  logic [15:0] kick_a, kick_b, snare_a, snare_b;

  dssm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_kick_ram (
    .clk(clk), .we(we_kick), .waddr(waddr), .wdata(ld_value),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(kick_a), .rdata_b(kick_b)
  );

  dssm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_snare_ram (
    .clk(clk), .we(we_snare), .waddr(waddr), .wdata(ld_value),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(snare_a), .rdata_b(snare_b)
  );

  // Floor mean of the pair that came back this cycle.
  logic [15:0] pa, pb;
  logic [16:0] pair_sum;
  logic [15:0] mean;
  always_comb begin
    pa       = rd_kick ? kick_a : snare_a;
    pb       = rd_kick ? kick_b : snare_b;
    pair_sum = {pa[15], pa} + {pb[15], pb};
    mean     = pair_sum[16:1];
  end

  logic signed [15:0] sat;
  always_comb begin
    if (!acc[SW-1] && (|acc[SW-2:15])) begin
      sat = 16'sh7fff;
    end else if (acc[SW-1] && !(&acc[SW-2:15])) begin
      sat = -16'sh8000;
    end else begin
      sat = acc[15:0];
    end
  end

  logic any_active;
  always_comb begin
    any_active = 1'b0;
    for (int v = 0; v < VOICES; v++) begin
      any_active = any_active | (voice_kind[v] != KIND_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_step <= SPS_WIDTH'(6000);
      step_count       <= 5'd16;
      pattern          <= 48'd4466950803467;
      kick_length      <= LEN_WIDTH'(4096);
      snare_length     <= LEN_WIDTH'(4096);
      paused           <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SAMPLES_PER_STEP: samples_per_step <= cfg_data[SPS_WIDTH-1:0];
        REG_STEP_COUNT:       step_count       <= cfg_data[4:0];
        REG_PATTERN:          pattern          <= cfg_data[47:0];
        REG_KICK_LENGTH:      kick_length      <= cfg_data[LEN_WIDTH-1:0];
        REG_SNARE_LENGTH:     snare_length     <= cfg_data[LEN_WIDTH-1:0];
        REG_PAUSED:           paused           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step_index     <= '0;
      step_countdown <= '0;
      hits           <= '0;
      mix_count      <= '0;
      rd_active      <= 1'b0;
      out_valid      <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        voice_kind[v]     <= KIND_IDLE;
        voice_position[v] <= '0;
      end
    end else begin
      rd_active <= mix_issue;
      rd_kick   <= mv_kick;
      if (state == S_OUTPUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            acc      <= '0;
            ld_addr  <= sample_address;
            ld_value <= sample_value;
            ld_kick  <= (command == CMD_LOAD_KICK);
            unique case (command)
              CMD_LOAD_KICK, CMD_LOAD_SNARE: begin
                state <= S_WRAP;
              end
              CMD_STOP: begin
                for (int v = 0; v < VOICES; v++) begin
                  voice_kind[v] <= KIND_IDLE;
                end
                step_index     <= '0;
                step_countdown <= '0;
                state          <= S_OUTPUT;
              end
              CMD_TICK: begin
                if (paused) begin
                  state <= S_OUTPUT;
                end else begin
                  if (step_countdown == '0) begin
                    step_countdown <= reload - SPS_WIDTH'(1);
                    hits           <= pattern[3*step_index +: 3];
                    step_index     <= (step_inc >= step_limit) ? '0 :
                                      step_inc[STEP_WIDTH-1:0];
                  end else begin
                    step_countdown <= step_countdown - SPS_WIDTH'(1);
                    hits           <= '0;
                  end
                  state <= S_FIRE;
                end
              end
              default: ;
            endcase
          end
        end
        S_WRAP: begin
          if (wrap_more) begin
            ld_addr <= ld_addr - 12'(SAMPLE_DEPTH);
          end else begin
            state <= S_OUTPUT;
          end
        end
        S_FIRE: begin
          if (hits == '0) begin
            mix_count <= '0;
            state     <= S_MIX;
          end else begin
            // A hit with no idle voice is simply dropped.
            if (claim_found) begin
              voice_kind[claim_idx]     <= claim_kind;
              voice_position[claim_idx] <= '0;
            end
            hits <= hits & (hits - hits_t'(1));
          end
        end
        S_MIX: begin
          if (mix_issue) begin
            voice_position[mv] <= mv_pos_next[LEN_WIDTH-1:0];
            if (mv_pos_next >= {1'b0, eff_len}) begin
              voice_kind[mv] <= KIND_IDLE;
            end
          end
          if (rd_active) begin
            acc <= acc + {{(SW-16){mean[15]}}, mean};
          end
          mix_count <= mix_count + CW'(1);
          if (mix_count == CW'(VOICES)) begin
            state <= S_OUTPUT;
          end
        end
        S_OUTPUT: begin
          if (!out_valid || !out_stall) begin
            audio_out <= sat;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_stop_frees_voices: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_STOP) |=> !any_active)
    else $error("voice still active after stop");

  a_result_from_output_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUTPUT)
    else $error("result raised outside output state");

  a_mix_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MIX |-> mix_count <= CW'(VOICES))
    else $error("voice walk ran past last voice");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (we_kick || we_snare) |-> 32'(ld_addr) < SAMPLE_DEPTH)
    else $error("sample write address not reduced");

  a_read_from_mix: assert property (@(posedge clk) disable iff (rst)
    rd_active |-> $past(state) == S_MIX)
    else $error("sample pair returned outside voice walk");

endmodule

// ===== sim/drum_step_sequencer_mixer_core_test.sv =====
// Self-checking testbench for the drum step sequencer mixer core.
module drum_step_sequencer_mixer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dssm_pkg::*;

  localparam int VOICES       = 4;
  localparam int SAMPLE_DEPTH = 4096;
  localparam int MAX_STEPS    = 16;
  localparam int CYCLE_LIMIT  = 3000000;
  // Words preloaded in each memory, and the most ticks allowed between two stops,
  // which keeps every voice read inside the preloaded words.
  localparam int PRELOAD      = 128;
  localparam int TICK_SPAN    = 60;

  typedef struct {
    cmd_t               command;
    logic [11:0]        addr;
    logic signed [15:0] value;
  } mixer_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  cmd_t                 command = CMD_TICK;
  logic [11:0]          sample_address = '0;
  logic signed [15:0]   sample_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [15:0]   audio_out;
  logic                 cfg_write = 1'b0;
  cfg_index_t           cfg_index = REG_SAMPLES_PER_STEP;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  // Register copies, at their reset values.
  logic [19:0] cfg_sps       = 20'd6000;
  logic [4:0]  cfg_steps     = 5'd16;
  logic [47:0] cfg_pattern   = 48'd4466950803467;
  logic [12:0] cfg_kick_len  = 13'd4096;
  logic [12:0] cfg_snare_len = 13'd4096;
  logic        cfg_paused    = 1'b0;

  // Sequencer and voice state.
  logic [12:0]        voice_pos [VOICES];
  kind_t              voice_kind [VOICES];
  logic [3:0]         step_idx = '0;
  logic [19:0]        countdown = '0;
  logic signed [15:0] kick_mem [SAMPLE_DEPTH];
  logic signed [15:0] snare_mem [SAMPLE_DEPTH];

  mixer_cmd_t         cmd_queue [$];
  logic signed [15:0] audio_expect [$];
  mixer_cmd_t         head_cmd;
  int                 items_issued = 0;
  int                 results_seen = 0;
  int                 fail_count = 0;
  int                 cycle_count = 0;
  int                 burst_left = 0;
  int                 gap_left = 0;
  int                 hold_left = 0;
  int                 stall_mode = 0;
  logic               pressure_done = 1'b0;

  drum_step_sequencer_mixer_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .sample_address (sample_address),
    .sample_value   (sample_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .audio_out      (audio_out),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    for (int v = 0; v < VOICES; v++) begin
      voice_pos[v] = '0;
      voice_kind[v] = KIND_IDLE;
    end
  end

  function automatic void claim_voice(kind_t kind);
    for (int v = 0; v < VOICES; v++) begin
      if (voice_kind[v] == KIND_IDLE) begin
        voice_kind[v] = kind;
        voice_pos[v] = '0;
        return;
      end
    end
  endfunction

  // Applies one beat to the state copy and returns the sample it should produce.
  function automatic logic signed [15:0] predict_audio(cmd_t cmd, logic [11:0] addr,
                                                       logic signed [15:0] word);
    int                 sum;
    int                 limit;
    int                 nxt;
    int                 len;
    int                 pos;
    hits_t              hits;
    logic               use_kick;
    logic signed [15:0] a;
    logic signed [15:0] b;
    sum = 0;
    case (cmd)
      CMD_LOAD_KICK: begin
        kick_mem[addr % SAMPLE_DEPTH] = word;
        return '0;
      end
      CMD_LOAD_SNARE: begin
        snare_mem[addr % SAMPLE_DEPTH] = word;
        return '0;
      end
      CMD_STOP: begin
        for (int v = 0; v < VOICES; v++) voice_kind[v] = KIND_IDLE;
        step_idx = '0;
        countdown = '0;
        return '0;
      end
      default: ;
    endcase
    if (cfg_paused) return '0;

    if (countdown == '0) begin
      countdown = (cfg_sps == '0) ? 20'd1 : cfg_sps;
      hits = cfg_pattern[3*step_idx +: 3];
      if ((hits & HIT_KICK) != '0) claim_voice(KIND_KICK);
      if ((hits & HIT_SNARE) != '0) claim_voice(KIND_SNARE);
      if ((hits & HIT_HIHAT) != '0) claim_voice(KIND_HIHAT);
      limit = (cfg_steps > MAX_STEPS) ? MAX_STEPS : cfg_steps;
      nxt = step_idx + 1;
      step_idx = (nxt >= limit) ? 4'd0 : nxt[3:0];
    end
    countdown = countdown - 20'd1;

    for (int v = 0; v < VOICES; v++) begin
      if (voice_kind[v] != KIND_IDLE) begin
        use_kick = (voice_kind[v] == KIND_KICK);
        len = use_kick ? cfg_kick_len : cfg_snare_len;
        if (len > SAMPLE_DEPTH) len = SAMPLE_DEPTH;
        pos = voice_pos[v];
        a = use_kick ? kick_mem[pos % SAMPLE_DEPTH] : snare_mem[pos % SAMPLE_DEPTH];
        b = use_kick ? kick_mem[(pos + 1) % SAMPLE_DEPTH]
                     : snare_mem[(pos + 1) % SAMPLE_DEPTH];
        sum += (int'(a) + int'(b)) >>> 1;
        pos += 2;
        voice_pos[v] = pos[12:0];
        if (pos >= len) voice_kind[v] = KIND_IDLE;
      end
    end
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    return sum[15:0];
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        audio_expect.push_back(predict_audio(command, sample_address, sample_value));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          head_cmd = cmd_queue.pop_front();
          in_valid <= 1'b1;
          command <= head_cmd.command;
          sample_address <= head_cmd.addr;
          sample_value <= head_cmd.value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = 1;
              2: gap_left = $urandom_range(1, 4);
              default: gap_left = $urandom_range(5, 24);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and stalls on a pattern of its own.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (audio_expect.size() == 0) begin
          $error("audio_out %0d arrived with no beat outstanding", audio_out);
          fail_count++;
        end else if (audio_out !== audio_expect[0]) begin
          $error("audio_out: expected %0d, got %0d", audio_expect[0], audio_out);
          fail_count++;
          void'(audio_expect.pop_front());
        end else begin
          void'(audio_expect.pop_front());
        end
      end
      if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
      // One long hold early on, while the preload keeps the sender busy.
      if (!pressure_done && results_seen >= 50) begin
        pressure_done = 1'b1;
        hold_left = 400;
      end else if (hold_left == 0 && $urandom_range(0, 4095) == 0) begin
        hold_left = $urandom_range(100, 300);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= cycle_count[2];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_cmd(cmd_t cmd, logic [11:0] addr, logic signed [15:0] value);
    mixer_cmd_t c;
    c.command = cmd;
    c.addr = addr;
    c.value = value;
    cmd_queue.push_back(c);
    items_issued++;
  endtask

  // Every beat yields one result, so the core is idle once all have come back.
  task automatic wait_for_audio();
    while (results_seen != items_issued) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Writes a register with random bits above its width, which the core must ignore.
  task automatic write_reg(cfg_index_t idx, logic [47:0] value);
    logic [47:0] data;
    data = 48'({$urandom, $urandom});
    case (idx)
      REG_SAMPLES_PER_STEP: begin
        data[19:0] = value[19:0];
        cfg_sps = data[19:0];
      end
      REG_STEP_COUNT: begin
        data[4:0] = value[4:0];
        cfg_steps = data[4:0];
      end
      REG_PATTERN: begin
        data = value;
        cfg_pattern = data;
      end
      REG_KICK_LENGTH: begin
        data[12:0] = value[12:0];
        cfg_kick_len = data[12:0];
      end
      REG_SNARE_LENGTH: begin
        data[12:0] = value[12:0];
        cfg_snare_len = data[12:0];
      end
      REG_PAUSED: begin
        data[0] = value[0];
        cfg_paused = data[0];
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [12:0] pick_length();
    case ($urandom_range(0, 9))
      0: return 13'($urandom_range(0, 3));
      1: return 13'd4096;
      2: return 13'($urandom_range(4097, 8191));
      default: return 13'(2 * $urandom_range(1, 32));
    endcase
  endfunction

  initial begin
    int r;
    int ticks_since_stop;
    logic [19:0] sps;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Fill the low words of both memories; regular stops keep every voice inside them.
    for (int a = 0; a < PRELOAD; a++) begin
      push_cmd(CMD_LOAD_KICK, 12'(a), 16'($urandom));
      push_cmd(CMD_LOAD_SNARE, 12'(a), 16'($urandom));
    end
    // A few ticks at the reset settings; the first step fires at once.
    repeat (6) push_cmd(CMD_TICK, 12'($urandom), 16'($urandom));
    push_cmd(CMD_STOP, 12'($urandom), 16'($urandom));
    wait_for_audio();

    // Zero period and zero step count act as one; zero and odd sample lengths.
    write_reg(REG_SAMPLES_PER_STEP, 48'd0);
    write_reg(REG_STEP_COUNT, 48'd0);
    write_reg(REG_PATTERN, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_KICK_LENGTH, 48'd0);
    write_reg(REG_SNARE_LENGTH, 48'd1);
    write_reg(REG_PAUSED, 48'd0);
    push_cmd(CMD_LOAD_KICK, 12'd0, 16'sh7FFF);
    push_cmd(CMD_LOAD_KICK, 12'd1, 16'sh7FFF);
    push_cmd(CMD_LOAD_SNARE, 12'd0, 16'sh7FFF);
    push_cmd(CMD_LOAD_SNARE, 12'd1, 16'sh7FFF);
    push_cmd(CMD_TICK, 12'hFFF, 16'shFFFF);
    push_cmd(CMD_LOAD_KICK, 12'd1, 16'sh8000);
    push_cmd(CMD_LOAD_SNARE, 12'd0, 16'sh8000);
    push_cmd(CMD_LOAD_SNARE, 12'd1, 16'sh8000);
    push_cmd(CMD_TICK, 12'd0, 16'sh0000);
    push_cmd(CMD_STOP, 12'hFFF, 16'sh7FFF);
    wait_for_audio();

    // All voices busy so later hits are dropped; a kick length beyond the memory depth.
    write_reg(REG_SAMPLES_PER_STEP, 48'd1);
    write_reg(REG_STEP_COUNT, 48'd31);
    write_reg(REG_KICK_LENGTH, 48'd8191);
    write_reg(REG_SNARE_LENGTH, 48'd4096);
    repeat (3) push_cmd(CMD_TICK, 12'($urandom), 16'($urandom));
    wait_for_audio();
    // Pause holds all state; a load still lands.
    write_reg(REG_PAUSED, 48'd1);
    push_cmd(CMD_TICK, 12'($urandom), 16'($urandom));
    push_cmd(CMD_LOAD_KICK, 12'd2, 16'sh1234);
    push_cmd(CMD_TICK, 12'($urandom), 16'($urandom));
    wait_for_audio();
    write_reg(REG_PAUSED, 48'd0);
    repeat (2) push_cmd(CMD_TICK, 12'($urandom), 16'($urandom));
    push_cmd(CMD_STOP, 12'($urandom), 16'($urandom));
    repeat (2) push_cmd(CMD_TICK, 12'($urandom), 16'($urandom));
    wait_for_audio();

    ticks_since_stop = 2;
    for (int phase = 0; phase < 20; phase++) begin
      case ($urandom_range(0, 9))
        0: sps = 20'd0;
        1: sps = 20'hFFFFF;
        default: sps = 20'($urandom_range(1, 6));
      endcase
      write_reg(REG_SAMPLES_PER_STEP, 48'(sps));
      write_reg(REG_STEP_COUNT, 48'($urandom_range(0, 31)));
      write_reg(REG_PATTERN, 48'({$urandom, $urandom}));
      write_reg(REG_KICK_LENGTH, 48'(pick_length()));
      write_reg(REG_SNARE_LENGTH, 48'(pick_length()));
      write_reg(REG_PAUSED, 48'($urandom_range(0, 7) == 0));
      for (int n = 0; n < 85; n++) begin
        r = $urandom_range(0, 99);
        if (ticks_since_stop >= TICK_SPAN || r >= 96) begin
          push_cmd(CMD_STOP, 12'($urandom), 16'($urandom));
          ticks_since_stop = 0;
        end else if (r < 80) begin
          push_cmd(CMD_TICK, 12'($urandom), 16'($urandom));
          ticks_since_stop++;
        end else if (r < 88) begin
          push_cmd(CMD_LOAD_KICK, 12'($urandom), 16'($urandom));
        end else begin
          push_cmd(CMD_LOAD_SNARE, 12'($urandom), 16'($urandom));
        end
      end
      wait_for_audio();
    end

    repeat (30) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== drum_step_sequencer_mixer_core.f =====
design/dssm_pkg.sv
design/dssm_ram.sv
design/drum_step_sequencer_mixer_core.sv
sim/drum_step_sequencer_mixer_core_test.sv
